// ===== hw/rtl/alle_pkg.sv =====
package alle_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_TAIL,
      ST_LINK,
      ST_REPLY
   } alle_state_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } alle_status_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_MODIFY = 2'd2
   } alle_kind_type;

   // commands from the sequencer to the slot map
   typedef struct packed {
      logic scan_start;
      logic scan_en;
      logic set_en;
      logic clr_en;
   } alle_slot_cmd_type;

   typedef struct packed {
      logic free_done;
      logic free_found;
   } alle_slot_stat_type;

endpackage

// ===== hw/rtl/array_linked_list_engine.sv =====
// channel  direction  ports                                         handshake
// req      in         req_kind, req_search_key, req_new_value       req_valid / req_ready
// rsp      out        rsp_status, rsp_slot_index, rsp_entry_count   rsp_valid / rsp_ready
//
// one item at a time; the list walk reads one entry per cycle from the data and
// link memories (insert walks the whole list, delete and modify stop at the
// first match).
// reset clears the slot valid bits, head and count at once; no clearing pass.
// the next item is taken while a result still waits on rsp; the engine holds
// in its reply state only when a second result would have to go out.
module array_linked_list_engine #(
   parameter int DEPTH = 8,
   parameter int DATA_WIDTH = 32,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int LINK_W = $clog2(DEPTH + 1),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_kind,
   input  logic signed [DATA_WIDTH-1:0] req_search_key,
   input  logic signed [DATA_WIDTH-1:0] req_new_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [IDX_W-1:0]             rsp_slot_index,
   output logic [CNT_W-1:0]             rsp_entry_count
);
   import alle_pkg::*;

   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(DEPTH);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);

   alle_state_type state_ff;
   alle_state_type state_in;

   logic [1:0]            kind_ff;
   logic [1:0]            kind_in;
   logic [DATA_WIDTH-1:0] key_ff;
   logic [DATA_WIDTH-1:0] key_in;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic [LINK_W-1:0]     cur_ff;
   logic [LINK_W-1:0]     cur_in;
   logic [LINK_W-1:0]     prev_ff;
   logic [LINK_W-1:0]     prev_in;
   logic [LINK_W-1:0]     steps_ff;
   logic [LINK_W-1:0]     steps_in;
   logic [LINK_W-1:0]     head_ff;
   logic [LINK_W-1:0]     head_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [1:0]            res_status_ff;
   logic [1:0]            res_status_in;
   logic [IDX_W-1:0]      res_slot_ff;
   logic [IDX_W-1:0]      res_slot_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [1:0]            rsp_status_in;
   logic [IDX_W-1:0]      rsp_slot_ff;
   logic [IDX_W-1:0]      rsp_slot_in;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic [CNT_W-1:0]      rsp_count_in;

   logic                  accept;
   logic                  out_free;
   logic                  is_find;
   logic                  is_early;
   logic                  match;
   logic                  walk_go;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] data_rd;
   logic [LINK_W-1:0]     link_rd;
   logic                  data_we;
   logic [IDX_W-1:0]      data_waddr;
   logic [DATA_WIDTH-1:0] data_wdata;
   logic                  link_we;
   logic [IDX_W-1:0]      link_waddr;
   logic [LINK_W-1:0]     link_wdata;

   alle_slot_cmd_type     slot_cmd;
   alle_slot_stat_type    slot_stat;
   logic [IDX_W-1:0]      set_idx;
   logic [IDX_W-1:0]      clr_idx;
   logic [LINK_W-1:0]     query_addr;
   logic                  query_live;
   logic [LINK_W-1:0]     free_idx;

   alle_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (data_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (data_rd)
   );

   alle_ram #(
      .WIDTH (LINK_W),
      .DEPTH (DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   alle_slot_map #(
      .DEPTH (DEPTH)
   ) u_slot_map (
      .clock      (clock),
      .reset      (reset),
      .cmd        (slot_cmd),
      .set_idx    (set_idx),
      .clr_idx    (clr_idx),
      .query_addr (query_addr),
      .query_live (query_live),
      .free_idx   (free_idx),
      .stat       (slot_stat)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_find   = (kind_ff == KIND_DELETE) || (kind_ff == KIND_MODIFY);
   assign match     = (data_rd == key_ff);

   // idle looks at the head, the walk looks at the link just read
   assign query_addr = (state_ff == ST_IDLE) ? head_ff : link_rd;
   assign walk_go    = (steps_ff < LINK_NONE) && query_live;

   // items that go straight to the reply without a walk: full, empty or an unknown kind
   always_comb begin
      is_early = 1'b0;
      if (req_kind == KIND_INSERT) begin
         is_early = (count_ff == CNT_FULL);
      end else if ((req_kind == KIND_DELETE) || (req_kind == KIND_MODIFY)) begin
         is_early = (count_ff == '0);
      end else begin
         is_early = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_early) begin
                  state_in = ST_REPLY;
               end else if (query_live) begin
                  state_in = ST_WALK;
               end else if (req_kind == KIND_INSERT) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_WALK: begin
            if (is_find && match) begin
               state_in = ST_REPLY;
            end else if (walk_go) begin
               state_in = ST_WALK;
            end else if (is_find) begin
               state_in = ST_REPLY;
            end else begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (slot_stat.free_done) begin
               if (slot_stat.free_found && (prev_ff != LINK_NONE)) begin
                  state_in = ST_LINK;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_LINK: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      kind_in       = kind_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff[IDX_W-1:0];
      data_we       = 1'b0;
      data_waddr    = cur_ff[IDX_W-1:0];
      data_wdata    = value_ff;
      link_we       = 1'b0;
      link_waddr    = prev_ff[IDX_W-1:0];
      link_wdata    = link_rd;
      slot_cmd      = '0;
      set_idx       = free_idx[IDX_W-1:0];
      clr_idx       = cur_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in             = req_kind;
               key_in              = req_search_key;
               value_in            = req_new_value;
               cur_in              = head_ff;
               prev_in             = LINK_NONE;
               steps_in            = LINK_W'(1);
               res_slot_in         = '0;
               res_status_in       = STAT_DONE;
               slot_cmd.scan_start = 1'b1;
               if (is_early) begin
                  if (req_kind == KIND_INSERT) begin
                     res_status_in = STAT_FULL;
                  end else if ((req_kind == KIND_DELETE) || (req_kind == KIND_MODIFY)) begin
                     res_status_in = STAT_EMPTY;
                  end
               end else if (query_live) begin
                  rd_en = 1'b1;
               end else if (req_kind != KIND_INSERT) begin
                  res_status_in = STAT_NOT_FOUND;
               end
            end
         end
         ST_WALK: begin
            slot_cmd.scan_en = 1'b1;
            if (is_find && match) begin
               res_slot_in = cur_ff[IDX_W-1:0];
               if (kind_ff == KIND_DELETE) begin
                  slot_cmd.clr_en = 1'b1;
                  count_in        = count_ff - CNT_W'(1);
                  // unlink: head moves, or the predecessor skips the hit
                  if (prev_ff == LINK_NONE) begin
                     head_in = link_rd;
                  end else begin
                     link_we = 1'b1;
                  end
               end else begin
                  data_we = 1'b1;
               end
            end else if (walk_go) begin
               rd_en    = 1'b1;
               rd_addr  = link_rd[IDX_W-1:0];
               prev_in  = cur_ff;
               cur_in   = link_rd;
               steps_in = steps_ff + LINK_W'(1);
            end else begin
               // prev now holds the tail
               prev_in = cur_ff;
               if (is_find) begin
                  res_status_in = STAT_NOT_FOUND;
               end
            end
         end
         ST_TAIL: begin
            slot_cmd.scan_en = 1'b1;
            if (slot_stat.free_done) begin
               if (slot_stat.free_found) begin
                  data_we         = 1'b1;
                  data_waddr      = free_idx[IDX_W-1:0];
                  data_wdata      = key_ff;
                  link_we         = 1'b1;
                  link_waddr      = free_idx[IDX_W-1:0];
                  link_wdata      = LINK_NONE;
                  slot_cmd.set_en = 1'b1;
                  count_in        = count_ff + CNT_W'(1);
                  res_slot_in     = free_idx[IDX_W-1:0];
                  if (prev_ff == LINK_NONE) begin
                     head_in = free_idx;
                  end
               end else begin
                  res_status_in = STAT_FULL;
               end
            end
         end
         ST_LINK: begin
            link_we    = 1'b1;
            link_waddr = prev_ff[IDX_W-1:0];
            link_wdata = LINK_W'(res_slot_ff);
         end
         ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      if ((state_ff == ST_REPLY) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
         rsp_count_in  = count_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= LINK_NONE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("engine idle right after taking an item");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1))
      || (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY) |-> (count_ff <= CNT_FULL))
      else $error("entry count above depth");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_REPLY) && out_free && (res_status_ff != STAT_DONE))
      |=> (rsp_slot_index == '0))
      else $error("failed item reports a nonzero slot");
`endif

endmodule

// ===== hw/rtl/alle_ram.sv =====
module alle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/alle_slot_map.sv =====
module alle_slot_map #(
   parameter int DEPTH = 8,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int LINK_W = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  alle_pkg::alle_slot_cmd_type cmd,
   input  logic [IDX_W-1:0]            set_idx,
   input  logic [IDX_W-1:0]            clr_idx,
   input  logic [LINK_W-1:0]           query_addr,
   output logic                        query_live,
   output logic [LINK_W-1:0]           free_idx,
   output alle_pkg::alle_slot_stat_type stat
);
   import alle_pkg::*;

   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(DEPTH);

   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;
   logic [LINK_W-1:0] scan_ff;
   logic [LINK_W-1:0] scan_in;
   logic              scan_hit;

   // a link is live when it is in range and its slot holds an entry
   assign query_live = (query_addr < LINK_NONE) && valid_ff[query_addr[IDX_W-1:0]];

   // scan for the lowest free slot, one slot per cycle while scan_en is set
   assign scan_hit        = (scan_ff < LINK_NONE) && valid_ff[scan_ff[IDX_W-1:0]];
   assign stat.free_done  = !scan_hit;
   assign stat.free_found = scan_ff < LINK_NONE;
   assign free_idx        = scan_ff;

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_start) begin
         scan_in = '0;
      end else if (cmd.scan_en && scan_hit) begin
         scan_in = scan_ff + LINK_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.set_en) begin
         valid_in[set_idx] = 1'b1;
      end
      if (cmd.clr_en) begin
         valid_in[clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         scan_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         scan_ff  <= scan_in;
      end
   end

endmodule
